// File: hdl/kdrlp_pkg.sv
// ----------------------------------------------------------------------------
// kdrlp_pkg
// Shared types and constants for the key debounce / repeat / long press block.
// ----------------------------------------------------------------------------
package kdrlp_pkg;

    // Fixed port shape: three keys, 6 event bits, 16-bit press time
    localparam int NUM_KEYS = 3;
    localparam int EV_W     = 6;
    localparam int PT_W     = 16;

    // Parameter defaults
    localparam int KEYS_DEF       = 3;
    localparam int TIME_WIDTH_DEF = 16;

    // Event bit positions
    localparam int EV_HELD    = 0;
    localparam int EV_PRESS   = 1;
    localparam int EV_RELEASE = 2;
    localparam int EV_REPEAT  = 3;
    localparam int EV_LONG    = 4;
    localparam int EV_SHORT   = 5;

    // Configuration register map (word index)
    localparam int REG_IDX_W = 2;
    localparam logic [REG_IDX_W-1:0] REG_DEBOUNCE = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_RPT_START = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_RPT_PERIOD = 2'd2;
    localparam logic [REG_IDX_W-1:0] REG_LONG = 2'd3;
    localparam int PADDR_W = REG_IDX_W + 2;

    // Register reset values
    localparam logic [7:0]  DEBOUNCE_RST   = 8'd2;
    localparam logic [7:0]  RPT_START_RST  = 8'd100;
    localparam logic [7:0]  RPT_PERIOD_RST = 8'd10;
    localparam logic [15:0] LONG_RST       = 16'd200;

    typedef struct packed {
        logic [7:0]  debounce;
        logic [7:0]  rpt_start;
        logic [7:0]  rpt_period;
        logic [15:0] long_ticks;
    } t_cfg;

endpackage

// File: hdl/kdrlp_regs.sv
// ----------------------------------------------------------------------------
// kdrlp_regs
// APB-style configuration registers: debounce, repeat start, repeat period
// and long-press count.
// ----------------------------------------------------------------------------
module kdrlp_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [kdrlp_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,
    output kdrlp_pkg::t_cfg                o_cfg
);
    import kdrlp_pkg::*;

    t_cfg                 r_cfg;
    logic                 w_wr;
    logic [REG_IDX_W-1:0] w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign w_idx  = paddr[PADDR_W-1:2];
    assign o_cfg  = r_cfg;

    // Write selected register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce   <= DEBOUNCE_RST;
            r_cfg.rpt_start  <= RPT_START_RST;
            r_cfg.rpt_period <= RPT_PERIOD_RST;
            r_cfg.long_ticks <= LONG_RST;
        end else if (w_wr) begin
            case (w_idx)
                REG_DEBOUNCE:   r_cfg.debounce   <= pwdata[7:0];
                REG_RPT_START:  r_cfg.rpt_start  <= pwdata[7:0];
                REG_RPT_PERIOD: r_cfg.rpt_period <= pwdata[7:0];
                REG_LONG:       r_cfg.long_ticks <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // Read back
    always_comb begin
        case (w_idx)
            REG_DEBOUNCE:   prdata = {24'd0, r_cfg.debounce};
            REG_RPT_START:  prdata = {24'd0, r_cfg.rpt_start};
            REG_RPT_PERIOD: prdata = {24'd0, r_cfg.rpt_period};
            REG_LONG:       prdata = {16'd0, r_cfg.long_ticks};
            default:        prdata = '0;
        endcase
    end

endmodule

// File: hdl/kdrlp_key.sv
// ----------------------------------------------------------------------------
// kdrlp_key
// One key: held flag, hold counter and saturating press timer, with the
// event decode for the current scan request.
// ----------------------------------------------------------------------------
module kdrlp_key #(
    parameter int TIME_WIDTH = kdrlp_pkg::TIME_WIDTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_advance,
    input  logic                       i_level,
    input  kdrlp_pkg::t_cfg            i_cfg,
    output logic [kdrlp_pkg::EV_W-1:0] o_events,
    output logic [kdrlp_pkg::PT_W-1:0] o_press_time
);
    import kdrlp_pkg::*;

    localparam int CW = (TIME_WIDTH > PT_W) ? TIME_WIDTH : PT_W;

    logic                  r_held, n_held;
    logic [7:0]            r_hc, n_hc;
    logic [TIME_WIDTH-1:0] r_pt, n_pt;
    logic [7:0]            w_hc_inc;
    logic                  w_not_max;
    logic [TIME_WIDTH-1:0] w_pt_inc;
    logic [CW-1:0]         w_pt_cw;
    logic [EV_W-1:0]       w_ev;

    assign w_hc_inc  = r_hc + 8'd1;
    assign w_not_max = (r_pt != '1);
    assign w_pt_inc  = w_not_max ? r_pt + TIME_WIDTH'(1) : r_pt;

    // Next state and events for this scan
    always_comb begin
        n_held         = r_held;
        n_hc           = r_hc;
        n_pt           = r_pt;
        w_ev           = '0;
        w_ev[EV_HELD]  = r_held;
        if (!i_level) begin
            n_hc = w_hc_inc;
            n_pt = w_pt_inc;
            if (!r_held) begin
                if (w_hc_inc == i_cfg.debounce) begin
                    n_held         = 1'b1;
                    n_pt           = TIME_WIDTH'(i_cfg.debounce);
                    w_ev[EV_HELD]  = 1'b1;
                    w_ev[EV_PRESS] = 1'b1;
                end
            end else begin
                if (w_hc_inc == i_cfg.rpt_start) begin
                    n_hc            = w_hc_inc - i_cfg.rpt_period;
                    w_ev[EV_REPEAT] = 1'b1;
                end
                if (w_not_max && (CW'(w_pt_inc) == CW'(i_cfg.long_ticks))) begin
                    w_ev[EV_LONG] = 1'b1;
                end
            end
        end else begin
            if (r_held) begin
                n_held           = 1'b0;
                w_ev[EV_RELEASE] = 1'b1;
                if (CW'(r_pt) < CW'(i_cfg.rpt_start)) begin
                    w_ev[EV_SHORT] = 1'b1;
                end
            end
            n_hc = 8'd0;
        end
    end

    // Report press time only while held
    assign w_pt_cw      = CW'(n_pt);
    assign o_events     = w_ev;
    assign o_press_time = w_ev[EV_HELD] ? w_pt_cw[PT_W-1:0] : '0;

    // Commit state when the request moves to the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= 1'b0;
            r_hc   <= '0;
            r_pt   <= '0;
        end else if (i_advance) begin
            r_held <= n_held;
            r_hc   <= n_hc;
            r_pt   <= n_pt;
        end
    end

endmodule

// File: hdl/key_debounce_repeat_long_press.sv
// ----------------------------------------------------------------------------
// key_debounce_repeat_long_press
// Three-key scanner with debounce, auto-repeat, long press and short press.
// ----------------------------------------------------------------------------
// Usage:
//   Each request on the input channel (i_in_valid / o_in_stall) is one scan
//   tick carrying the active-low levels of three keys. Each tick yields one
//   result on the output channel (o_out_valid / i_out_stall): six event bits
//   and the press time per key, plus an any-event flag.
//   The request is captured in an input register, decoded against the
//   per-key counters, and held in the result register. Throughput is one
//   request per cycle while the receiver does not stall; the per-key
//   counter update is a single increment and compare, and the counters are
//   written in the same cycle the result register loads.
//   When the receiver stalls, the result register holds and the input
//   register still takes one more request; a further request is stalled
//   until the result is taken. Reset clears all held flags, counters and
//   timers and loads the register defaults (debounce 2, repeat start 100,
//   repeat period 10, long press 200). The user must write configuration over
//   the APB port while no request is in flight; the block does not enforce it.
// ----------------------------------------------------------------------------
module key_debounce_repeat_long_press #(
    parameter int KEYS       = kdrlp_pkg::KEYS_DEF,
    parameter int TIME_WIDTH = kdrlp_pkg::TIME_WIDTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [kdrlp_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic                           i_key1_level,
    input  logic                           i_key2_level,
    input  logic                           i_key3_level,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [kdrlp_pkg::EV_W-1:0]     o_key1_events,
    output logic [kdrlp_pkg::EV_W-1:0]     o_key2_events,
    output logic [kdrlp_pkg::EV_W-1:0]     o_key3_events,
    output logic [kdrlp_pkg::PT_W-1:0]     o_key1_press_time,
    output logic [kdrlp_pkg::PT_W-1:0]     o_key2_press_time,
    output logic [kdrlp_pkg::PT_W-1:0]     o_key3_press_time,
    output logic                           o_any_event
);
    import kdrlp_pkg::*;

    t_cfg                  w_cfg;
    logic                  r_in_valid;
    logic [NUM_KEYS-1:0]   r_in_level;
    logic                  r_out_valid;
    logic [EV_W-1:0]       r_ev [NUM_KEYS];
    logic [PT_W-1:0]       r_pt [NUM_KEYS];
    logic                  r_any;
    logic [EV_W-1:0]       w_ev [NUM_KEYS];
    logic [PT_W-1:0]       w_pt [NUM_KEYS];
    logic [NUM_KEYS-1:0]   w_ev_nz;
    logic                  w_out_ready;
    logic                  w_advance;
    logic                  w_accept;

    kdrlp_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // Handshake: result register frees up, input register moves forward
    assign w_out_ready = !r_out_valid || !i_out_stall;
    assign w_advance   = r_in_valid && w_out_ready;
    assign o_in_stall  = r_in_valid && !w_out_ready;
    assign w_accept    = i_in_valid && !o_in_stall;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in_level <= {i_key3_level, i_key2_level, i_key1_level};
        end
    end

    // Per-key scanners; keys past KEYS report nothing
    for (genvar k = 0; k < NUM_KEYS; k++) begin : g_key
        if (k < KEYS) begin : g_on
            kdrlp_key #(
                .TIME_WIDTH (TIME_WIDTH)
            ) u_key (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_advance    (w_advance),
                .i_level      (r_in_level[k]),
                .i_cfg        (w_cfg),
                .o_events     (w_ev[k]),
                .o_press_time (w_pt[k])
            );
        end else begin : g_off
            assign w_ev[k] = '0;
            assign w_pt[k] = '0;
        end
        assign w_ev_nz[k] = |w_ev[k];
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_ev  <= w_ev;
            r_pt  <= w_pt;
            r_any <= |w_ev_nz;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_key1_events     = r_ev[0];
    assign o_key2_events     = r_ev[1];
    assign o_key3_events     = r_ev[2];
    assign o_key1_press_time = r_pt[0];
    assign o_key2_press_time = r_pt[1];
    assign o_key3_press_time = r_pt[2];
    assign o_any_event       = r_any;

    // Checks
    a_stall_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_in_valid)
        else $error("input stalled with empty input register");

    a_advance_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_advance |=> r_out_valid)
        else $error("result register not loaded after advance");

    for (genvar k = 0; k < NUM_KEYS; k++) begin : g_chk
        a_time_needs_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
            (r_out_valid && (r_pt[k] != '0)) |-> r_ev[k][EV_HELD])
            else $error("press time reported for a key that is not held");

        a_press_not_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
            r_out_valid |-> !(r_ev[k][EV_PRESS] && r_ev[k][EV_RELEASE]))
            else $error("press and release in the same tick");

        a_short_needs_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
            (r_out_valid && r_ev[k][EV_SHORT]) |-> r_ev[k][EV_RELEASE])
            else $error("short press without release");
    end

endmodule

// File: tb/key_debounce_repeat_long_press_test.sv
// ----------------------------------------------------------------------------
// key_debounce_repeat_long_press_test
// Self-checking bench for the three-key debounce / repeat / long press scanner.
// Scan requests are sent through bursty valid/stall traffic. Each request goes
// through a cycle-free model of the key counters, and each result is compared
// field by field. The register settings are changed over APB between phases.
// The phases cover tiny counts, the reset defaults, the register extremes, a
// long press at or below the debounce count, and one key held for a long run.
// ----------------------------------------------------------------------------
module key_debounce_repeat_long_press_test;

    timeunit 1ns;
    timeprecision 1ps;

    import kdrlp_pkg::*;

    localparam int LIMIT_CYCLES = 2_000_000;
    localparam int REPORT_MAX   = 10;

    typedef logic [NUM_KEYS-1:0] t_levels;

    typedef struct packed {
        logic [NUM_KEYS-1:0][EV_W-1:0] ev;
        logic [NUM_KEYS-1:0][PT_W-1:0] pt;
        logic                          any;
    } t_key_report;

    // DUT ports
    logic              i_clk;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;
    logic              i_in_valid;
    logic              o_in_stall;
    logic              i_key1_level;
    logic              i_key2_level;
    logic              i_key3_level;
    logic              o_out_valid;
    logic              i_out_stall;
    logic [EV_W-1:0]   o_key1_events;
    logic [EV_W-1:0]   o_key2_events;
    logic [EV_W-1:0]   o_key3_events;
    logic [PT_W-1:0]   o_key1_press_time;
    logic [PT_W-1:0]   o_key2_press_time;
    logic [PT_W-1:0]   o_key3_press_time;
    logic              o_any_event;

    // Scan levels waiting to be sent, and reports owed by the block
    t_levels     pending_scans[$];
    t_key_report owed_reports[$];

    // Model of the key counters and the live register values
    t_cfg            key_cfg = '{debounce: DEBOUNCE_RST, rpt_start: RPT_START_RST,
                                 rpt_period: RPT_PERIOD_RST, long_ticks: LONG_RST};
    logic            key_held  [NUM_KEYS] = '{default: 1'b0};
    logic [7:0]      hold_cnt  [NUM_KEYS] = '{default: 8'd0};
    logic [PT_W-1:0] key_timer [NUM_KEYS] = '{default: '0};

    // Level run generator, one run per key
    logic            run_level [NUM_KEYS] = '{default: 1'b1};
    int              run_left  [NUM_KEYS] = '{default: 0};

    // Traffic shaping
    int   burst_left = 0;
    int   gap_left   = 0;
    logic scan_taken = 1'b0;
    logic hold_off   = 1'b0;
    int   stall_cycle = 0;

    // Bookkeeping
    int   cycle_count     = 0;
    int   scans_accepted  = 0;
    int   reports_checked = 0;
    int   mismatches      = 0;
    int   settings_used   = 0;

    key_debounce_repeat_long_press dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_key1_level      (i_key1_level),
        .i_key2_level      (i_key2_level),
        .i_key3_level      (i_key3_level),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_key1_events     (o_key1_events),
        .o_key2_events     (o_key2_events),
        .o_key3_events     (o_key3_events),
        .o_key1_press_time (o_key1_press_time),
        .o_key2_press_time (o_key2_press_time),
        .o_key3_press_time (o_key3_press_time),
        .o_any_event       (o_any_event)
    );

    // Clock: 4 ns period
    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    // Advance every key by one scan tick and return the report it yields
    function automatic t_key_report scan_keys(t_levels lv);
        t_key_report     r;
        logic [EV_W-1:0] ev;
        logic [PT_W-1:0] prev;
        r = '0;
        for (int k = 0; k < NUM_KEYS; k++) begin
            ev = '0;
            ev[EV_HELD] = key_held[k];
            if (!lv[k]) begin
                prev = key_timer[k];
                hold_cnt[k] = hold_cnt[k] + 8'd1;
                if (prev != '1)
                    key_timer[k] = prev + 1'b1;
                if (!key_held[k]) begin
                    if (hold_cnt[k] == key_cfg.debounce) begin
                        key_held[k]    = 1'b1;
                        key_timer[k]   = PT_W'(key_cfg.debounce);
                        ev[EV_HELD]    = 1'b1;
                        ev[EV_PRESS]   = 1'b1;
                    end
                end else begin
                    if (hold_cnt[k] == key_cfg.rpt_start) begin
                        hold_cnt[k]  = hold_cnt[k] - key_cfg.rpt_period;
                        ev[EV_REPEAT] = 1'b1;
                    end
                    if (key_timer[k] != prev && key_timer[k] == key_cfg.long_ticks)
                        ev[EV_LONG] = 1'b1;
                end
            end else begin
                if (key_held[k]) begin
                    key_held[k]    = 1'b0;
                    ev[EV_RELEASE] = 1'b1;
                    if (key_timer[k] < PT_W'(key_cfg.rpt_start))
                        ev[EV_SHORT] = 1'b1;
                end
                hold_cnt[k] = 8'd0;
            end
            r.ev[k] = ev;
            r.pt[k] = ev[EV_HELD] ? key_timer[k] : '0;
            if (ev != '0)
                r.any = 1'b1;
        end
        return r;
    endfunction

    // Pick the next level of one key from runs sized to the live settings
    function automatic logic next_level(int k);
        int extra;
        if (run_left[k] == 0) begin
            run_level[k] = !run_level[k];
            if (!run_level[k]) begin
                extra = int'(key_cfg.rpt_start) + 3 * int'(key_cfg.rpt_period);
                if (key_cfg.long_ticks < 512 && int'(key_cfg.long_ticks) + 4 > extra)
                    extra = int'(key_cfg.long_ticks) + 4;
                // mostly full presses, some bounces shorter than the debounce
                if ($urandom_range(0, 4) == 0)
                    run_left[k] = $urandom_range(1, (key_cfg.debounce > 1) ?
                                                    key_cfg.debounce - 1 : 1);
                else
                    run_left[k] = key_cfg.debounce + $urandom_range(0, extra);
            end else begin
                run_left[k] = ($urandom_range(0, 3) == 0) ? $urandom_range(7, 40)
                                                          : $urandom_range(1, 6);
            end
        end
        run_left[k]--;
        return run_level[k];
    endfunction

    task automatic add_random_scans(int count, bit pin_key1);
        t_levels lv;
        for (int n = 0; n < count; n++) begin
            for (int k = 0; k < NUM_KEYS; k++)
                lv[k] = next_level(k);
            if (pin_key1)
                lv[0] = 1'b0;
            pending_scans.push_back(lv);
        end
    endtask

    task automatic push_scan(logic k1, logic k2, logic k3);
        pending_scans.push_back({k3, k2, k1});
    endtask

    // APB write: setup cycle, then access until pready
    task automatic write_register(logic [REG_IDX_W-1:0] idx, logic [31:0] value);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = value;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        case (idx)
            REG_DEBOUNCE:   key_cfg.debounce   = value[7:0];
            REG_RPT_START:  key_cfg.rpt_start  = value[7:0];
            REG_RPT_PERIOD: key_cfg.rpt_period = value[7:0];
            REG_LONG:       key_cfg.long_ticks = value[15:0];
            default: ;
        endcase
    endtask

    task automatic wait_drained();
        while (pending_scans.size() != 0 || i_in_valid || owed_reports.size() != 0)
            @(posedge i_clk);
    endtask

    // Drain the block, let the pipeline settle, then load a new setting
    task automatic apply_setting(int deb, int start, int period, int long_at);
        wait_drained();
        repeat (4) @(posedge i_clk);
        write_register(REG_DEBOUNCE,   32'(deb));
        write_register(REG_RPT_START,  32'(start));
        write_register(REG_RPT_PERIOD, 32'(period));
        write_register(REG_LONG,       32'(long_at));
        settings_used++;
    endtask

    task automatic flag_mismatch(string what, int key, int want, int got);
        mismatches++;
        if (mismatches <= REPORT_MAX)
            $display("mismatch on report %0d: %s key%0d expected 0x%0h got 0x%0h",
                     reports_checked, what, key, want, got);
    endtask

    // Sender: bursts of random length with random gaps
    always @(negedge i_clk) begin : drive_scans
        logic    nv;
        t_levels nl;
        nv = i_in_valid;
        nl = {i_key3_level, i_key2_level, i_key1_level};
        if (!i_rst_n) begin
            nv = 1'b0;
        end else if (!i_in_valid || scan_taken) begin
            nv = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
            end else if (pending_scans.size() > 0) begin
                nl = pending_scans.pop_front();
                nv = 1'b1;
                if (burst_left <= 1) begin
                    burst_left = $urandom_range(1, 40);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
                end else begin
                    burst_left--;
                end
            end
        end
        i_in_valid   <= nv;
        i_key1_level <= nl[0];
        i_key2_level <= nl[1];
        i_key3_level <= nl[2];
    end

    // Receiver: the stall pattern steps through four modes, plus the hold-off
    always @(negedge i_clk) begin : drive_stall
        logic pat;
        case (stall_cycle[7:6])
            2'd0: pat = 1'b0;
            2'd1: pat = ($urandom_range(0, 2) == 0);
            2'd2: pat = (stall_cycle[1:0] == 2'd0);
            default: pat = $urandom_range(0, 1);
        endcase
        stall_cycle++;
        i_out_stall <= hold_off | pat;
    end

    // Hold off the receiver for a long stretch while scans keep coming
    initial begin
        while (scans_accepted < 300)
            @(posedge i_clk);
        hold_off = 1'b1;
        repeat (150) @(posedge i_clk);
        hold_off = 1'b0;
    end

    // Record accepted requests and check delivered reports
    always @(posedge i_clk) begin : watch_ports
        t_key_report got;
        t_key_report want;
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            owed_reports.push_back(scan_keys({i_key3_level, i_key2_level, i_key1_level}));
            scans_accepted++;
        end
        scan_taken <= i_rst_n && i_in_valid && !o_in_stall;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got.ev  = {o_key3_events, o_key2_events, o_key1_events};
            got.pt  = {o_key3_press_time, o_key2_press_time, o_key1_press_time};
            got.any = o_any_event;
            if (owed_reports.size() == 0) begin
                flag_mismatch("report with no request", 0, 0, 0);
            end else begin
                want = owed_reports.pop_front();
                for (int k = 0; k < NUM_KEYS; k++) begin
                    if (got.ev[k] !== want.ev[k])
                        flag_mismatch("events", k + 1, want.ev[k], got.ev[k]);
                    if (got.pt[k] !== want.pt[k])
                        flag_mismatch("press time", k + 1, want.pt[k], got.pt[k]);
                end
                if (got.any !== want.any)
                    flag_mismatch("any_event", 0, want.any, got.any);
            end
            reports_checked++;
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("watchdog expired after %0d cycles", cycle_count);
            $display("FAILED: results differ");
            $finish;
        end
    end

    // Stimulus and end of run
    initial begin : run_phases
        int deb;
        int start;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        i_in_valid   = 1'b0;
        i_key1_level = 1'b1;
        i_key2_level = 1'b1;
        i_key3_level = 1'b1;
        i_out_stall  = 1'b0;
        i_rst_n      = 1'b0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: tiny counts so every event shows up within a few ticks
        apply_setting(1, 4, 1, 6);
        push_scan(1, 1, 1);
        push_scan(0, 0, 1);     // key1 and key2 accepted at once
        push_scan(0, 0, 0);
        push_scan(0, 1, 0);     // key2 short press
        push_scan(0, 1, 1);     // key1 first repeat, key3 short press
        push_scan(0, 1, 1);
        push_scan(0, 1, 1);     // key1 long press together with repeat
        push_scan(0, 1, 1);
        push_scan(1, 1, 1);     // key1 release past the repeat start
        push_scan(0, 1, 1);
        push_scan(1, 1, 1);

        // Reset defaults
        apply_setting(DEBOUNCE_RST, RPT_START_RST, RPT_PERIOD_RST, LONG_RST);
        add_random_scans(250, 1'b0);

        // Long press at or below the debounce count, shortest repeat
        apply_setting(3, 2, 1, 2);
        add_random_scans(200, 1'b0);

        // Upper register extremes
        apply_setting(255, 255, 254, 65535);
        add_random_scans(500, 1'b0);

        // Hold key1 down through many repeats and one long press
        apply_setting(1, 2, 1, 200);
        add_random_scans(250, 1'b1);
        push_scan(1, 1, 1);

        // Random small settings; keys may still be held across the change
        repeat (4) begin
            deb   = $urandom_range(1, 6);
            start = $urandom_range(2, 40);
            apply_setting(deb, start, $urandom_range(1, start - 1), $urandom_range(1, 120));
            add_random_scans(80, 1'b0);
        end

        wait_drained();
        repeat (10) @(posedge i_clk);
        $display("checked %0d scan reports across %0d register settings, %0d mismatches",
                 reports_checked, settings_used, mismatches);
        if (mismatches == 0 && owed_reports.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
